/* rtl/mp2d_pkg.sv */
`default_nettype none
package mp2d_pkg;

  localparam int DEF_MAX_PLANE_COLS = 1024;
  localparam int DEF_MAX_PLANE_ROWS = 1024;
  localparam int DEF_MAX_WINDOW     = 8;
  localparam int DEF_MAX_MARGIN     = 4;
  localparam int DEF_SAMPLE_BITS    = 16;

  localparam int POS_BITS      = 11;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 11;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PLANE_ROWS  = 4'd0,
    REG_PLANE_COLS  = 4'd1,
    REG_WINDOW_ROWS = 4'd2,
    REG_WINDOW_COLS = 4'd3,
    REG_STEP_ROWS   = 4'd4,
    REG_STEP_COLS   = 4'd5,
    REG_MARGIN_ROWS = 4'd6,
    REG_MARGIN_COLS = 4'd7
  } cfg_reg_e;

endpackage
`default_nettype wire

/* rtl/mp2d_sample_if.sv */
`default_nettype none
interface mp2d_sample_if #(
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface
`default_nettype wire

/* rtl/mp2d_result_if.sv */
`default_nettype none
interface mp2d_result_if #(
  parameter int SAMPLE_BITS = mp2d_pkg::DEF_SAMPLE_BITS
);
  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_BITS-1:0]     window_max;
  logic [mp2d_pkg::POS_BITS-1:0]     out_row;
  logic [mp2d_pkg::POS_BITS-1:0]     out_col;
  logic                              run_end;
  logic                              plane_end;

  modport source (output valid, output window_max, output out_row, output out_col,
                  output run_end, output plane_end, input ready);
  modport sink (input valid, input window_max, input out_row, input out_col,
                input run_end, input plane_end, output ready);
endinterface
`default_nettype wire

/* rtl/mp2d_cfg_if.sv */
`default_nettype none
interface mp2d_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mp2d_pkg::CFG_IDX_BITS-1:0]  index;
  logic [mp2d_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/max_pool_2d_stream_top.sv */
`default_nettype none
// channel  dir  payload                                        beat when
// in_i     in   sample                                         valid && ready
// out_o    out  window_max, out_row, out_col, run_end, plane_end valid && ready
// cfg_i    in   index, data                                    valid && ready
//
// one sample is taken at a time: the write, then window select, then finish
// each window adds a scan, a drain and an output step: the single read port of the line memory
// scans the real rows x cols of the window, then come the drain and the output state;
// every window after the first of a sample adds one more window select
// a sample that closes no window passes only through the write, window select and finish
// reset clears counters and registers; the line memory needs no clearing
// a stalled output holds the block; no sample is taken while a result waits
// a register write is taken only while idle and goes ahead of a waiting sample
module max_pool_2d_stream_top #(
  parameter int MAX_PLANE_COLS = mp2d_pkg::DEF_MAX_PLANE_COLS,
  parameter int MAX_PLANE_ROWS = mp2d_pkg::DEF_MAX_PLANE_ROWS,
  parameter int MAX_WINDOW     = mp2d_pkg::DEF_MAX_WINDOW,
  parameter int MAX_MARGIN     = mp2d_pkg::DEF_MAX_MARGIN,
  parameter int SAMPLE_BITS    = mp2d_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mp2d_sample_if.sink  in_i,
  mp2d_result_if.source out_o,
  mp2d_cfg_if.sink     cfg_i
);
  import mp2d_pkg::*;

  localparam int MAXP = (MAX_PLANE_ROWS > MAX_PLANE_COLS) ? MAX_PLANE_ROWS : MAX_PLANE_COLS;
  localparam int XW   = $clog2(MAXP + 2 * MAX_MARGIN + 4 * MAX_WINDOW + 1) + 1;
  localparam int RW   = $clog2(MAX_PLANE_ROWS);
  localparam int CW   = $clog2(MAX_PLANE_COLS);
  localparam int SW   = $clog2(MAX_WINDOW);
  localparam int DEPTH = MAX_WINDOW * MAX_PLANE_COLS;
  localparam int AW   = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEL, ST_SCAN, ST_DRAIN, ST_EMIT, ST_DONE
  } state_e;

  state_e state_q;

  logic [CFG_DATA_BITS-1:0] plane_rows_q, plane_cols_q;
  logic [3:0] window_rows_q, window_cols_q, step_rows_q, step_cols_q;
  logic [2:0] margin_rows_q, margin_cols_q;

  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [SW-1:0] slot_q;
  logic [XW-1:0] ri_q, rstart_q, cj_q, cstart_q;
  logic [XW-1:0] ii_q, istart_q, jj_q, jstart_q;

  logic [SW-1:0] scan_slot_q, scan_rleft_q;
  logic [CW-1:0] scan_cc_q, scan_c0_q;
  logic          rd_valid_q;
  logic signed [SAMPLE_BITS-1:0] rdata_q, max_q;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  logic signed [SAMPLE_BITS-1:0] wmax_q;
  logic [POS_BITS-1:0] orow_q, ocol_q;
  logic run_end_q, plane_end_q;

  logic [XW-1:0] r_eff, c_eff, kh, kw, sh, sw, pr, pc, r_pos, c_pos;
  logic [XW-1:0] mr, mc;

  function automatic logic win_fits(input logic [XW-1:0] start, k, p, n);
    return (start + k) <= (n + (p << 1));
  endfunction

  function automatic logic win_hit(input logic [XW-1:0] start, k, p, n, pos);
    logic [XW-1:0] endv;
    endv = start + k - XW'(1) - p;
    return win_fits(start, k, p, n) &&
           ((endv == pos) || ((pos == n - XW'(1)) && (endv > pos)));
  endfunction

  function automatic logic win_ends(input logic [XW-1:0] start, k, p, n, pos);
    return win_fits(start, k, p, n) && ((start + k - XW'(1) - p) == pos);
  endfunction

  always_comb begin
    r_eff = XW'(plane_rows_q);
    if (r_eff == '0) r_eff = XW'(1);
    else if (r_eff > XW'(MAX_PLANE_ROWS)) r_eff = XW'(MAX_PLANE_ROWS);
    c_eff = XW'(plane_cols_q);
    if (c_eff == '0) c_eff = XW'(1);
    else if (c_eff > XW'(MAX_PLANE_COLS)) c_eff = XW'(MAX_PLANE_COLS);
    kh = XW'(window_rows_q);
    if (kh == '0) kh = XW'(1);
    else if (kh > XW'(MAX_WINDOW)) kh = XW'(MAX_WINDOW);
    kw = XW'(window_cols_q);
    if (kw == '0) kw = XW'(1);
    else if (kw > XW'(MAX_WINDOW)) kw = XW'(MAX_WINDOW);
    sh = (step_rows_q == '0) ? XW'(1) : XW'(step_rows_q);
    sw = (step_cols_q == '0) ? XW'(1) : XW'(step_cols_q);
    mr = XW'(margin_rows_q);
    if (mr > XW'(MAX_MARGIN)) mr = XW'(MAX_MARGIN);
    pr = (mr > (kh >> 1)) ? (kh >> 1) : mr;
    mc = XW'(margin_cols_q);
    if (mc > XW'(MAX_MARGIN)) mc = XW'(MAX_MARGIN);
    pc = (mc > (kw >> 1)) ? (kw >> 1) : mc;
    r_pos = XW'(row_q);
    c_pos = XW'(col_q);
  end

  // window setup
  logic [XW-1:0] r0, c0;
  logic [SW-1:0] nrows;
  logic [SW-1:0] first_slot;
  always_comb begin
    r0 = (istart_q > pr) ? (istart_q - pr) : '0;
    c0 = (jstart_q > pc) ? (jstart_q - pc) : '0;
    nrows = SW'(r_pos - r0);
    first_slot = (slot_q >= nrows) ? (slot_q - nrows)
                                   : SW'(XW'(slot_q) + XW'(MAX_WINDOW) - XW'(nrows));
  end

  logic next_col_hit, next_row_hit, last_i, last_j;
  always_comb begin
    next_col_hit = win_hit(jstart_q + sw, kw, pc, c_eff, c_pos);
    next_row_hit = win_hit(istart_q + sh, kh, pr, r_eff, r_pos);
    last_i = !win_fits(istart_q + sh, kh, pr, r_eff);
    last_j = !win_fits(jstart_q + sw, kw, pc, c_eff);
  end

  logic signed [SAMPLE_BITS-1:0] folded;
  assign folded = (rd_valid_q && (rdata_q > max_q)) ? rdata_q : max_q;

  logic [AW-1:0] waddr, raddr;
  assign waddr = AW'(int'(slot_q) * MAX_PLANE_COLS + int'(col_q));
  assign raddr = AW'(int'(scan_slot_q) * MAX_PLANE_COLS + int'(scan_cc_q));

  logic in_beat, out_beat;
  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      mem[waddr] <= in_i.sample;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plane_rows_q <= CFG_DATA_BITS'(1);
      plane_cols_q <= CFG_DATA_BITS'(1);
      window_rows_q <= 4'd2;
      window_cols_q <= 4'd2;
      step_rows_q <= 4'd2;
      step_cols_q <= 4'd2;
      margin_rows_q <= '0;
      margin_cols_q <= '0;
      row_q <= '0;
      col_q <= '0;
      slot_q <= '0;
      ri_q <= '0;
      rstart_q <= '0;
      cj_q <= '0;
      cstart_q <= '0;
      ii_q <= '0;
      istart_q <= '0;
      jj_q <= '0;
      jstart_q <= '0;
      scan_slot_q <= '0;
      scan_rleft_q <= '0;
      scan_cc_q <= '0;
      scan_c0_q <= '0;
      rd_valid_q <= 1'b0;
      max_q <= '0;
      wmax_q <= '0;
      orow_q <= '0;
      ocol_q <= '0;
      run_end_q <= 1'b0;
      plane_end_q <= 1'b0;
    end else begin
      rd_valid_q <= (state_q == ST_SCAN);

      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index < CFG_IDX_BITS'(8)) begin
          row_q <= '0;
          col_q <= '0;
          slot_q <= '0;
          ri_q <= '0;
          rstart_q <= '0;
          cj_q <= '0;
          cstart_q <= '0;
        end
        case (cfg_reg_e'(cfg_i.index))
          REG_PLANE_ROWS:  plane_rows_q <= cfg_i.data;
          REG_PLANE_COLS:  plane_cols_q <= cfg_i.data;
          REG_WINDOW_ROWS: window_rows_q <= cfg_i.data[3:0];
          REG_WINDOW_COLS: window_cols_q <= cfg_i.data[3:0];
          REG_STEP_ROWS:   step_rows_q <= cfg_i.data[3:0];
          REG_STEP_COLS:   step_cols_q <= cfg_i.data[3:0];
          REG_MARGIN_ROWS: margin_rows_q <= cfg_i.data[2:0];
          REG_MARGIN_COLS: margin_cols_q <= cfg_i.data[2:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            ii_q <= ri_q;
            istart_q <= rstart_q;
            jj_q <= cj_q;
            jstart_q <= cstart_q;
            state_q <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (win_hit(istart_q, kh, pr, r_eff, r_pos) &&
              win_hit(jstart_q, kw, pc, c_eff, c_pos)) begin
            scan_slot_q <= first_slot;
            scan_rleft_q <= nrows;
            scan_cc_q <= CW'(c0);
            scan_c0_q <= CW'(c0);
            max_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SCAN: begin
          max_q <= folded;
          if (scan_cc_q == col_q) begin
            if (scan_rleft_q == '0) begin
              state_q <= ST_DRAIN;
            end else begin
              scan_cc_q <= scan_c0_q;
              scan_rleft_q <= scan_rleft_q - SW'(1);
              scan_slot_q <= (scan_slot_q == SW'(MAX_WINDOW - 1)) ? '0
                                                                  : scan_slot_q + SW'(1);
            end
          end else begin
            scan_cc_q <= scan_cc_q + CW'(1);
          end
        end
        ST_DRAIN: begin
          wmax_q <= folded;
          orow_q <= POS_BITS'(ii_q);
          ocol_q <= POS_BITS'(jj_q);
          run_end_q <= !next_col_hit && !next_row_hit;
          plane_end_q <= last_i && last_j;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_beat) begin
            if (next_col_hit) begin
              jj_q <= jj_q + XW'(1);
              jstart_q <= jstart_q + sw;
              state_q <= ST_SEL;
            end else if (next_row_hit) begin
              ii_q <= ii_q + XW'(1);
              istart_q <= istart_q + sh;
              jj_q <= cj_q;
              jstart_q <= cstart_q;
              state_q <= ST_SEL;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (c_pos == c_eff - XW'(1)) begin
            col_q <= '0;
            cj_q <= '0;
            cstart_q <= '0;
            if (r_pos == r_eff - XW'(1)) begin
              row_q <= '0;
              slot_q <= '0;
              ri_q <= '0;
              rstart_q <= '0;
            end else begin
              row_q <= row_q + RW'(1);
              slot_q <= (slot_q == SW'(MAX_WINDOW - 1)) ? '0 : slot_q + SW'(1);
              if (win_ends(rstart_q, kh, pr, r_eff, r_pos)) begin
                ri_q <= ri_q + XW'(1);
                rstart_q <= rstart_q + sh;
              end
            end
          end else begin
            col_q <= col_q + CW'(1);
            if (win_ends(cstart_q, kw, pc, c_eff, c_pos)) begin
              cj_q <= cj_q + XW'(1);
              cstart_q <= cstart_q + sw;
            end
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid       = (state_q == ST_EMIT);
  assign out_o.window_max  = wmax_q;
  assign out_o.out_row     = orow_q;
  assign out_o.out_col     = ocol_q;
  assign out_o.run_end     = run_end_q;
  assign out_o.plane_end   = plane_end_q;

  a_row_in_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_pos < r_eff) else $error("row position beyond plane");

  a_col_in_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_pos < c_eff) else $error("column position beyond plane");

  a_no_take_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> !out_o.valid) else $error("sample taken while result pending");

  a_run_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && out_o.run_end) |=> (state_q == ST_DONE))
    else $error("run did not close after last beat");

endmodule
`default_nettype wire

/* tb/tb_max_pool_2d_stream_top.sv */
`default_nettype none
module tb_max_pool_2d_stream_top;
  import mp2d_pkg::*;

  localparam int SBITS      = DEF_SAMPLE_BITS;
  localparam int LINE_LEN   = DEF_MAX_PLANE_COLS + 2 * DEF_MAX_MARGIN;
  localparam int MAX_BURST  = 25;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [SBITS-1:0] window_max;
    logic [POS_BITS-1:0]     out_row;
    logic [POS_BITS-1:0]     out_col;
    logic                    run_end;
    logic                    plane_end;
  } pool_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  mp2d_sample_if in_if ();
  mp2d_result_if out_if ();
  mp2d_cfg_if    cfg_if ();

  max_pool_2d_stream_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // shadow registers and line memory of the pooling predictor
  logic [10:0] plane_rows, plane_cols;
  logic [3:0]  window_rows, window_cols, step_rows, step_cols;
  logic [2:0]  margin_rows, margin_cols;
  logic signed [SBITS-1:0] line_mem [DEF_MAX_WINDOW*LINE_LEN];
  int unsigned row_pos, col_pos;

  logic signed [SBITS-1:0] sample_q [$];
  pool_result_t            window_q [$];
  int  mismatches = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_go = 1'b0;
  bit  long_hold_taken = 1'b0;
  int  tx_gap, rx_gap, hold_left, quiet_cycles;

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned window_count(int unsigned n, int unsigned pad,
                                               int unsigned k, int unsigned s);
    if (k > n + 2 * pad) return 0;
    return (n + 2 * pad - k) / s + 1;
  endfunction

  function automatic int unsigned last_real(int unsigned start, int unsigned pad,
                                            int unsigned k, int unsigned n);
    int unsigned e;
    e = start + k - 1;
    if (e > pad + n - 1) e = pad + n - 1;
    return e - pad;
  endfunction

  task automatic predict_windows(input logic signed [SBITS-1:0] s);
    int unsigned R, C, kh, kw, sh, sw, pr, pc, r, c, oh, ow, i, j, rs, cs, r0, c0, rr, cc;
    int n;
    logic signed [SBITS-1:0] mx;
    pool_result_t res;
    pool_result_t batch [$];
    R  = clampu(plane_rows, 1, DEF_MAX_PLANE_ROWS);
    C  = clampu(plane_cols, 1, DEF_MAX_PLANE_COLS);
    kh = clampu(window_rows, 1, DEF_MAX_WINDOW);
    kw = clampu(window_cols, 1, DEF_MAX_WINDOW);
    sh = step_rows == 0 ? 1 : step_rows;
    sw = step_cols == 0 ? 1 : step_cols;
    pr = clampu(margin_rows, 0, DEF_MAX_MARGIN);
    pc = clampu(margin_cols, 0, DEF_MAX_MARGIN);
    if (pr > kh / 2) pr = kh / 2;
    if (pc > kw / 2) pc = kw / 2;
    r = row_pos >= R ? 0 : row_pos;
    c = col_pos >= C ? 0 : col_pos;
    line_mem[(r % DEF_MAX_WINDOW) * LINE_LEN + c] = s;
    oh = window_count(R, pr, kh, sh);
    ow = window_count(C, pc, kw, sw);
    n = 0;
    for (i = 0; i < oh; i++) begin
      rs = i * sh;
      if (last_real(rs, pr, kh, R) != r) continue;
      for (j = 0; j < ow; j++) begin
        cs = j * sw;
        if (last_real(cs, pc, kw, C) != c) continue;
        r0 = rs > pr ? rs - pr : 0;
        c0 = cs > pc ? cs - pc : 0;
        mx = {1'b1, {(SBITS-1){1'b0}}};
        for (rr = r0; rr <= r; rr++)
          for (cc = c0; cc <= c; cc++)
            if (line_mem[(rr % DEF_MAX_WINDOW) * LINE_LEN + cc] > mx)
              mx = line_mem[(rr % DEF_MAX_WINDOW) * LINE_LEN + cc];
        if (n < MAX_BURST) begin
          res.window_max = mx;
          res.out_row    = i[POS_BITS-1:0];
          res.out_col    = j[POS_BITS-1:0];
          res.run_end    = 1'b0;
          res.plane_end  = (i == oh - 1 && j == ow - 1);
          batch.push_back(res);
          n++;
        end
      end
    end
    if (n > 0) batch[n-1].run_end = 1'b1;
    foreach (batch[k]) window_q.push_back(batch[k]);
    c++;
    if (c >= C) begin
      c = 0;
      r++;
      if (r >= R) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.sample <= '0;
      tx_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_windows(in_if.sample);
      if (in_if.valid && !in_if.ready) begin
      end else if (tx_gap > 0) begin
        in_if.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (sample_q.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.sample <= sample_q.pop_front();
        if (idle_on && $urandom_range(0, 3) == 0) tx_gap <= $urandom_range(1, 5);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap <= 0;
      hold_left <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.window_max, out_if.out_row, out_if.out_col,
                out_if.run_end, out_if.plane_end};
        if (window_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", got);
        end else begin
          want = window_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (long_hold_go && !long_hold_taken) begin
        long_hold_taken <= 1'b1;
        hold_left <= HOLD_LEN;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) rx_gap <= $urandom_range(1, 5);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("max_pool_2d_stream_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [10:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx <= REG_MARGIN_COLS) begin
      case (cfg_reg_e'(idx))
        REG_PLANE_ROWS:  plane_rows  = val;
        REG_PLANE_COLS:  plane_cols  = val;
        REG_WINDOW_ROWS: window_rows = val[3:0];
        REG_WINDOW_COLS: window_cols = val[3:0];
        REG_STEP_ROWS:   step_rows   = val[3:0];
        REG_STEP_COLS:   step_cols   = val[3:0];
        REG_MARGIN_ROWS: margin_rows = val[2:0];
        REG_MARGIN_COLS: margin_cols = val[2:0];
        default: ;
      endcase
      row_pos = 0;
      col_pos = 0;
    end
  endtask

  task automatic set_pooling(input int pr, pc, kr, kc, sr, sc, mr, mc);
    write_reg(REG_PLANE_ROWS, 11'(pr));
    write_reg(REG_PLANE_COLS, 11'(pc));
    write_reg(REG_WINDOW_ROWS, 11'(kr));
    write_reg(REG_WINDOW_COLS, 11'(kc));
    write_reg(REG_STEP_ROWS, 11'(sr));
    write_reg(REG_STEP_COLS, 11'(sc));
    write_reg(REG_MARGIN_ROWS, 11'(mr));
    write_reg(REG_MARGIN_COLS, 11'(mc));
  endtask

  function automatic logic signed [SBITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SBITS'($urandom());
    endcase
  endfunction

  task automatic send_samples(input int n);
    for (int k = 0; k < n; k++) sample_q.push_back(pick_sample());
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_if.valid || window_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    int rows, cols;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    plane_rows = 1; plane_cols = 1;
    window_rows = 2; window_cols = 2;
    step_rows = 2; step_cols = 2;
    margin_rows = 0; margin_cols = 0;
    row_pos = 0; col_pos = 0;
    foreach (line_mem[k]) line_mem[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting: kernel larger than the plane, no results
    send_samples(2);
    drain();
    // small padded plane with extremes
    set_pooling(3, 4, 2, 2, 1, 1, 1, 1);
    sample_q.push_back(16'sh8000); sample_q.push_back(16'sh7fff);
    sample_q.push_back(16'sh0000); sample_q.push_back(16'shffff);
    send_samples(8);
    drain();
    // margin above half the kernel, out-of-range index ignored
    set_pooling(4, 3, 3, 3, 2, 2, 4, 7);
    write_reg(CFG_IDX_BITS'($urandom_range(8, 15)), 11'h7ff);
    send_samples(6);
    drain();
    // largest kernel and padding: many windows on the last sample
    set_pooling(2, 2, 8, 8, 1, 1, 4, 4);
    send_samples(4);
    drain();

    // receiver holds off while the block fills up
    set_pooling(4, 8, 1, 1, 1, 1, 0, 0);
    long_hold_go = 1'b1;
    send_samples(32);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 7) idle_on = 1'b0;
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0: rows = $urandom_range(0, 1) ? 0 : 2047;
        1: cols = $urandom_range(0, 1) ? 0 : 1024;
        2: cols = 2047;
        default: ;
      endcase
      set_pooling(rows, cols, $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 7), $urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(8, 15)), 11'($urandom()));
      if ($urandom_range(0, 4) == 0) set_pooling(rows, cols, 1, 1, 1, 1, 0, 0);
      send_samples(rows >= 1 && rows <= 6 && cols >= 1 && cols <= 8 ?
                   ((rows * cols > 20) ? rows * cols : 2 * rows * cols) : 20);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && window_q.size() == 0) begin
      $display("max_pool_2d_stream_top test passed");
    end else begin
      $display("max_pool_2d_stream_top test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
